@@ hw/rtl/stq_pkg.sv @@
// stq_pkg: shared types, codes and helper functions of the sorted timer queue
// used by stq_cell and sorted_timer_task_queue_core, no dependencies
`default_nettype none

package stq_pkg;

  // largest queue depth the prefix network covers
  localparam int unsigned MaxDepth = 256;
  localparam int unsigned PrefixLevels = 8;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned MaxTimeoutWidth = 31;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [TimeWidth-1:0] IdleWaitReset = 32'd1000;
  localparam logic [MaxTimeoutWidth-1:0] MaxTimeoutReset = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_POLL     = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_TOO_LARGE = 2'd3
  } status_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_IDLE_WAIT   = 2'd0,
    CFG_MAX_TIMEOUT = 2'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_INSERT
  } state_e;

  // per-cell load selects, highest priority first
  typedef struct packed {
    logic take_new;
    logic take_prev;
    logic take_next;
  } cell_ctrl_t;

  typedef struct packed {
    logic match;
    logic later;
  } cell_flag_t;

  // a later than b with wrap-around
  function automatic logic later_than(logic [TimeWidth-1:0] a, logic [TimeWidth-1:0] b);
    logic [TimeWidth-1:0] d;
    d = a - b;
    return (d != '0) && !d[TimeWidth-1];
  endfunction

  // inclusive prefix or, log-depth
  function automatic logic [MaxDepth-1:0] prefix_or(logic [MaxDepth-1:0] v);
    logic [MaxDepth-1:0] r;
    logic [MaxDepth-1:0] n;
    r = v;
    for (int s = 0; s < PrefixLevels; s++) begin
      n = r;
      for (int i = 0; i < MaxDepth; i++) begin
        if (i >= (1 << s)) begin
          n[i] = r[i] | r[i - (1 << s)];
        end
      end
      r = n;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/stq_cell.sv @@
// stq_cell: one slot of the sorted queue chain, holds expiry and key
// loads from its neighbours or the new entry; depends on stq_pkg
`default_nettype none

module stq_cell #(
  parameter int unsigned TASK_ID_WIDTH = 8,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  wire                              clk_i,
  input  stq_pkg::cell_ctrl_t              ctrl_i,
  input  wire                              occ_i,
  input  wire [stq_pkg::TimeWidth-1:0]     new_exp_i,
  input  wire [TASK_ID_WIDTH-1:0]          new_task_i,
  input  wire [DATA_WIDTH-1:0]             new_data_i,
  input  wire [stq_pkg::TimeWidth-1:0]     prev_exp_i,
  input  wire [TASK_ID_WIDTH-1:0]          prev_task_i,
  input  wire [DATA_WIDTH-1:0]             prev_data_i,
  input  wire [stq_pkg::TimeWidth-1:0]     next_exp_i,
  input  wire [TASK_ID_WIDTH-1:0]          next_task_i,
  input  wire [DATA_WIDTH-1:0]             next_data_i,
  output logic [stq_pkg::TimeWidth-1:0]    exp_o,
  output logic [TASK_ID_WIDTH-1:0]         task_o,
  output logic [DATA_WIDTH-1:0]            data_o,
  output stq_pkg::cell_flag_t              flag_o
);
  import stq_pkg::*;

  logic [TimeWidth-1:0]     exp_q, exp_d;
  logic [TASK_ID_WIDTH-1:0] task_q, task_d;
  logic [DATA_WIDTH-1:0]    data_q, data_d;

  always_comb begin
    exp_d  = exp_q;
    task_d = task_q;
    data_d = data_q;
    priority if (ctrl_i.take_new) begin
      exp_d  = new_exp_i;
      task_d = new_task_i;
      data_d = new_data_i;
    end else if (ctrl_i.take_prev) begin
      exp_d  = prev_exp_i;
      task_d = prev_task_i;
      data_d = prev_data_i;
    end else if (ctrl_i.take_next) begin
      exp_d  = next_exp_i;
      task_d = next_task_i;
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q  <= exp_d;
    task_q <= task_d;
    data_q <= data_d;
  end

  // an empty slot counts as later so the insert point falls on the fill level
  assign flag_o.later = !occ_i || later_than(exp_q, new_exp_i);
  assign flag_o.match = occ_i && (task_q == new_task_i) && (data_q == new_data_i);

  assign exp_o  = exp_q;
  assign task_o = task_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

@@ hw/rtl/sorted_timer_task_queue_core.sv @@
// sorted_timer_task_queue_core: top level of the sorted timer queue
// chain of stq_cell slots plus request sequencer; depends on stq_pkg, stq_cell
`default_nettype none

// Keeps up to QUEUE_DEPTH timed tasks in a chain of cells ordered by wrap-aware
// 32-bit expiry, slot 0 being the head. Requests (register, remove, poll) are
// taken one at a time: a request is latched on its transfer and then worked by
// the cell chain, which makes one shift per cycle. Remove and poll load their
// result into the output register from the exec state; register first drops an
// entry with the same key in the exec state, then shifts in the new entry in
// the insert state (a timeout over the limit loads its result in exec). The
// next request is taken in the cycle after the result is loaded. While a loaded
// result is held by stall the following request waits in exec or insert, but a
// register's drop pass still goes ahead. Configuration writes are taken in
// every cycle; index 0 sets idle_wait, index 1 max_timeout, other indices are
// ignored.
module sorted_timer_task_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TASK_ID_WIDTH = 8,
  parameter int unsigned DATA_WIDTH = 16,
  localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // request channel
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire [1:0]                           req_type_i,
  input  wire [stq_pkg::TimeWidth-1:0]        now_i,
  input  wire [stq_pkg::TimeWidth-1:0]        timeout_i,
  input  wire [TASK_ID_WIDTH-1:0]             task_id_i,
  input  wire [DATA_WIDTH-1:0]                data_handle_i,
  // result channel
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [1:0]                          status_o,
  output logic                                fired_o,
  output logic [TASK_ID_WIDTH-1:0]            fired_task_id_o,
  output logic [DATA_WIDTH-1:0]               fired_data_handle_o,
  output logic [stq_pkg::TimeWidth-1:0]       wait_time_o,
  output logic [CntWidth-1:0]                 occupancy_o,
  // configuration write channel
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire [stq_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  wire [stq_pkg::CfgDataWidth-1:0]     cfg_data_i
);
  import stq_pkg::*;

  state_e state_q, state_d;

  logic [CntWidth-1:0]        count_q, count_d;
  logic [TimeWidth-1:0]       idle_wait_q;
  logic [MaxTimeoutWidth-1:0] max_timeout_q;

  // latched request
  logic [1:0]               req_q;
  logic [TimeWidth-1:0]     now_q;
  logic [TimeWidth-1:0]     timeout_q;
  logic [TimeWidth-1:0]     exp_q;
  logic [TASK_ID_WIDTH-1:0] task_q;
  logic [DATA_WIDTH-1:0]    data_q;

  // result register
  logic                     out_valid_q, out_valid_d;
  logic                     load_res;
  status_e                  res_status;
  logic                     res_fired;
  logic [TimeWidth-1:0]     res_wait;
  logic [1:0]               status_q;
  logic                     fired_q;
  logic [TASK_ID_WIDTH-1:0] ftask_q;
  logic [DATA_WIDTH-1:0]    fdata_q;
  logic [TimeWidth-1:0]     wait_q;
  logic [CntWidth-1:0]      occ_q;

  // chain wiring
  logic [TimeWidth-1:0]     cell_exp  [QUEUE_DEPTH];
  logic [TASK_ID_WIDTH-1:0] cell_task [QUEUE_DEPTH];
  logic [DATA_WIDTH-1:0]    cell_data [QUEUE_DEPTH];
  cell_flag_t               cell_flag [QUEUE_DEPTH];
  cell_ctrl_t               cell_ctrl [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   occ;
  logic [QUEUE_DEPTH-1:0]   match_vec, later_vec;
  logic [QUEUE_DEPTH-1:0]   del_sel, ins_sel, ins_prev;
  logic [MaxDepth-1:0]      match_pad, later_pad, del_pref, ins_pref;

  logic in_xfer, out_free, found;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [TimeWidth-1:0]     prev_exp, next_exp;
    logic [TASK_ID_WIDTH-1:0] prev_task, next_task;
    logic [DATA_WIDTH-1:0]    prev_data, next_data;

    if (i == 0) begin : g_head
      assign prev_exp  = '0;
      assign prev_task = '0;
      assign prev_data = '0;
    end else begin : g_body
      assign prev_exp  = cell_exp[i-1];
      assign prev_task = cell_task[i-1];
      assign prev_data = cell_data[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_exp  = cell_exp[i];
      assign next_task = cell_task[i];
      assign next_data = cell_data[i];
    end else begin : g_inner
      assign next_exp  = cell_exp[i+1];
      assign next_task = cell_task[i+1];
      assign next_data = cell_data[i+1];
    end

    assign occ[i]       = (CntWidth'(i) < count_q);
    assign match_vec[i] = cell_flag[i].match;
    assign later_vec[i] = cell_flag[i].later;

    stq_cell #(
      .TASK_ID_WIDTH(TASK_ID_WIDTH),
      .DATA_WIDTH   (DATA_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[i]),
      .occ_i      (occ[i]),
      .new_exp_i  (exp_q),
      .new_task_i (task_q),
      .new_data_i (data_q),
      .prev_exp_i (prev_exp),
      .prev_task_i(prev_task),
      .prev_data_i(prev_data),
      .next_exp_i (next_exp),
      .next_task_i(next_task),
      .next_data_i(next_data),
      .exp_o      (cell_exp[i]),
      .task_o     (cell_task[i]),
      .data_o     (cell_data[i]),
      .flag_o     (cell_flag[i])
    );
  end

  // slots at and after the match close up; slots after the insert point open up
  always_comb begin
    match_pad = '0;
    later_pad = '0;
    match_pad[QUEUE_DEPTH-1:0] = match_vec;
    later_pad[QUEUE_DEPTH-1:0] = later_vec;
    del_pref = prefix_or(match_pad);
    ins_pref = prefix_or(later_pad);
    del_sel  = del_pref[QUEUE_DEPTH-1:0];
    ins_prev = {ins_pref[QUEUE_DEPTH-2:0], 1'b0};
    ins_sel  = ins_pref[QUEUE_DEPTH-1:0] & ~ins_prev;
  end

  assign found = |match_vec;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    load_res   = 1'b0;
    res_status = STS_OK;
    res_fired  = 1'b0;
    res_wait   = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_ctrl[i] = '0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (req_q)
          REQ_REGISTER: begin
            if (timeout_q > {1'b0, max_timeout_q}) begin
              if (out_free) begin
                load_res   = 1'b1;
                res_status = STS_TOO_LARGE;
                state_d    = S_IDLE;
              end
            end else begin
              // drop an entry with the same key before inserting
              for (int i = 0; i < QUEUE_DEPTH; i++) begin
                cell_ctrl[i].take_next = del_sel[i];
              end
              if (found) begin
                count_d = count_q - CntWidth'(1);
              end
              state_d = S_INSERT;
            end
          end
          REQ_REMOVE: begin
            if (out_free) begin
              for (int i = 0; i < QUEUE_DEPTH; i++) begin
                cell_ctrl[i].take_next = del_sel[i];
              end
              if (found) begin
                count_d = count_q - CntWidth'(1);
              end
              load_res   = 1'b1;
              res_status = found ? STS_OK : STS_NOT_FOUND;
              state_d    = S_IDLE;
            end
          end
          REQ_POLL: begin
            if (out_free) begin
              load_res = 1'b1;
              state_d  = S_IDLE;
              if (count_q == '0) begin
                res_wait = idle_wait_q;
              end else if (!later_than(cell_exp[0], now_q)) begin
                res_fired = 1'b1;
                count_d   = count_q - CntWidth'(1);
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  cell_ctrl[i].take_next = 1'b1;
                end
              end else begin
                res_wait = cell_exp[0] - now_q;
              end
            end
          end
          default: begin
            // unused request code: plain result
            if (out_free) begin
              load_res = 1'b1;
              state_d  = S_IDLE;
            end
          end
        endcase
      end
      S_INSERT: begin
        if (out_free) begin
          load_res = 1'b1;
          state_d  = S_IDLE;
          if (count_q >= CntWidth'(QUEUE_DEPTH)) begin
            res_status = STS_FULL;
          end else begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              cell_ctrl[i].take_new  = ins_sel[i];
              cell_ctrl[i].take_prev = ins_prev[i];
            end
            count_d = count_q + CntWidth'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load_res) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_wait_q   <= IdleWaitReset;
      max_timeout_q <= MaxTimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IDLE_WAIT:   idle_wait_q   <= cfg_data_i;
        CFG_MAX_TIMEOUT: max_timeout_q <= cfg_data_i[MaxTimeoutWidth-1:0];
        default: ;
      endcase
    end
  end

  // request latch, expiry worked out on the transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q     <= req_type_i;
      now_q     <= now_i;
      timeout_q <= timeout_i;
      exp_q     <= now_i + timeout_i;
      task_q    <= task_id_i;
      data_q    <= data_handle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      status_q <= res_status;
      fired_q  <= res_fired;
      ftask_q  <= res_fired ? cell_task[0] : '0;
      fdata_q  <= res_fired ? cell_data[0] : '0;
      wait_q   <= res_wait;
      occ_q    <= count_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign fired_o             = fired_q;
  assign fired_task_id_o     = ftask_q;
  assign fired_data_handle_o = fdata_q;
  assign wait_time_o         = wait_q;
  assign occupancy_o         = occ_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntWidth'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_fired_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && fired_q) |-> (status_q == STS_OK && wait_q == '0))
    else $error("fired result carries status or wait time");

  a_result_from_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) != S_IDLE))
    else $error("result loaded without a request in progress");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (count_q == $past(count_q)))
    else $error("queue count moved while idle");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// tb: self-checking testbench for sorted_timer_task_queue_core
// drives register, remove and poll requests plus config writes, predicts each result
// depends on stq_pkg and the core rtl only
`timescale 1ns / 100ps

module tb;
  import stq_pkg::*;

  localparam int unsigned QDepth = 16;
  localparam int unsigned TaskW = 8;
  localparam int unsigned HandleW = 16;
  localparam int unsigned KeyPool = 20;
  localparam int unsigned IdlePct = 19;
  localparam int unsigned LongHold = 80;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned MaxReports = 10;
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam logic [CfgIndexWidth-1:0] CfgSpareIndex = 2'd3;

  typedef enum logic [2:0] {
    OP_REQUEST,
    OP_CONFIG,
    OP_DRAIN,
    OP_HOLD,
    OP_CALM_ON,
    OP_CALM_OFF
  } sched_kind_e;

  typedef struct packed {
    sched_kind_e kind;
    logic [1:0] req;
    logic [31:0] now;
    logic [31:0] timeout;
    logic [TaskW-1:0] task_id;
    logic [HandleW-1:0] handle;
    logic [CfgIndexWidth-1:0] cfg_idx;
    logic [CfgDataWidth-1:0] cfg_val;
  } sched_op_t;

  typedef struct packed {
    status_e status;
    logic fired;
    logic [TaskW-1:0] task_id;
    logic [HandleW-1:0] handle;
    logic [31:0] wait_ms;
    logic [4:0] occupancy;
  } timer_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [31:0] now_i = '0;
  logic [31:0] timeout_i = '0;
  logic [TaskW-1:0] task_id_i = '0;
  logic [HandleW-1:0] data_handle_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic fired_o;
  logic [TaskW-1:0] fired_task_id_o;
  logic [HandleW-1:0] fired_data_handle_o;
  logic [31:0] wait_time_o;
  logic [4:0] occupancy_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  sorted_timer_task_queue_core #(
    .QUEUE_DEPTH(QDepth),
    .TASK_ID_WIDTH(TaskW),
    .DATA_WIDTH(HandleW)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .req_type_i(req_type_i),
    .now_i(now_i),
    .timeout_i(timeout_i),
    .task_id_i(task_id_i),
    .data_handle_i(data_handle_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o(status_o),
    .fired_o(fired_o),
    .fired_task_id_o(fired_task_id_o),
    .fired_data_handle_o(fired_data_handle_o),
    .wait_time_o(wait_time_o),
    .occupancy_o(occupancy_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // predicted queue contents, slot 0 is the head
  logic [31:0] q_expiry [QDepth];
  logic [TaskW-1:0] q_task [QDepth];
  logic [HandleW-1:0] q_handle [QDepth];
  int unsigned q_count = 0;
  logic [31:0] idle_wait_cfg = IdleWaitReset;
  logic [30:0] max_timeout_cfg = MaxTimeoutReset;

  sched_op_t stim_q[$];
  timer_result_t expected_q[$];

  bit req_accepted = 1'b0;
  bit cfg_accepted = 1'b0;
  bit send_req, send_cfg;
  bit calm = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned settle_cnt = 0;

  int unsigned mismatches = 0;
  int unsigned failures = 0;
  int unsigned n_results = 0;
  int unsigned n_register = 0, n_remove = 0, n_poll = 0, n_unused = 0;
  int unsigned n_fired = 0, n_full = 0, n_too_large = 0, n_not_found = 0;

  logic [31:0] gen_clock;
  logic [TaskW-1:0] pool_task [KeyPool];
  logic [HandleW-1:0] pool_handle [KeyPool];

  // ---------------------------------------------------------------- predictor

  function automatic bit expires_after(logic [31:0] a, logic [31:0] b);
    return $signed(a - b) > 0;
  endfunction

  function automatic void drop_slot(int unsigned pos);
    for (int unsigned i = pos; i + 1 < q_count; i++) begin
      q_expiry[i] = q_expiry[i + 1];
      q_task[i] = q_task[i + 1];
      q_handle[i] = q_handle[i + 1];
    end
    q_count--;
  endfunction

  function automatic bit unlink_key(logic [TaskW-1:0] tid, logic [HandleW-1:0] hnd);
    for (int unsigned i = 0; i < q_count; i++) begin
      if (q_task[i] == tid && q_handle[i] == hnd) begin
        drop_slot(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic timer_result_t timer_queue_step(sched_op_t op);
    timer_result_t r;
    logic [31:0] due;
    int unsigned pos;
    r = '0;
    case (op.req)
      REQ_REGISTER: begin
        if (op.timeout > {1'b0, max_timeout_cfg}) begin
          r.status = STS_TOO_LARGE;
        end else begin
          due = op.now + op.timeout;
          void'(unlink_key(op.task_id, op.handle));
          if (q_count >= QDepth) begin
            r.status = STS_FULL;
          end else begin
            pos = 0;
            // equal expiry goes behind the entries already queued
            while (pos < q_count && !expires_after(q_expiry[pos], due)) pos++;
            for (int unsigned i = q_count; i > pos; i--) begin
              q_expiry[i] = q_expiry[i - 1];
              q_task[i] = q_task[i - 1];
              q_handle[i] = q_handle[i - 1];
            end
            q_expiry[pos] = due;
            q_task[pos] = op.task_id;
            q_handle[pos] = op.handle;
            q_count++;
          end
        end
      end
      REQ_REMOVE: begin
        r.status = unlink_key(op.task_id, op.handle) ? STS_OK : STS_NOT_FOUND;
      end
      REQ_POLL: begin
        if (q_count == 0) begin
          r.wait_ms = idle_wait_cfg;
        end else if (!expires_after(q_expiry[0], op.now)) begin
          r.fired = 1'b1;
          r.task_id = q_task[0];
          r.handle = q_handle[0];
          drop_slot(0);
        end else begin
          r.wait_ms = q_expiry[0] - op.now;
        end
      end
      default: ;
    endcase
    r.occupancy = q_count[4:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_request(logic [1:0] req, logic [31:0] now, logic [31:0] tmo,
                                       logic [TaskW-1:0] tid, logic [HandleW-1:0] hnd);
    sched_op_t op;
    op = '0;
    op.kind = OP_REQUEST;
    op.req = req;
    op.now = now;
    op.timeout = tmo;
    op.task_id = tid;
    op.handle = hnd;
    stim_q.push_back(op);
  endfunction

  function automatic void push_marker(sched_kind_e kind);
    sched_op_t op;
    op = '0;
    op.kind = kind;
    stim_q.push_back(op);
  endfunction

  function automatic void push_config(logic [CfgIndexWidth-1:0] idx, logic [31:0] val);
    sched_op_t op;
    op = '0;
    op.kind = OP_CONFIG;
    op.cfg_idx = idx;
    op.cfg_val = val;
    stim_q.push_back(op);
  endfunction

  // mostly well-formed traffic on a small key pool so keys collide and the queue fills
  function automatic void push_random(int unsigned count);
    int unsigned pick, k;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, KeyPool - 1);
      gen_clock = gen_clock + $urandom_range(0, 24);
      if (pick < 40) begin
        push_request(REQ_REGISTER, gen_clock,
                     ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 400),
                     pool_task[k], pool_handle[k]);
      end else if (pick < 55) begin
        push_request(REQ_REMOVE, gen_clock, $urandom, pool_task[k], pool_handle[k]);
      end else if (pick < 90) begin
        push_request(REQ_POLL, gen_clock, $urandom, pool_task[k], pool_handle[k]);
      end else begin
        push_request(2'($urandom_range(0, 3)), $urandom, $urandom,
                     TaskW'($urandom_range(0, 255)), HandleW'($urandom_range(0, 65535)));
      end
    end
  endfunction

  // ---------------------------------------------------------------- clock, reset

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- sender

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else if ((in_valid_i && !req_accepted) || (cfg_valid_i && !cfg_accepted)) begin
      // stalled transfer keeps its payload
    end else begin
      send_req = 1'b0;
      send_cfg = 1'b0;
      if (stim_q.size() != 0) begin
        case (stim_q[0].kind)
          OP_REQUEST: begin
            if (calm || $urandom_range(0, 99) >= IdlePct) begin
              req_type_i <= stim_q[0].req;
              now_i <= stim_q[0].now;
              timeout_i <= stim_q[0].timeout;
              task_id_i <= stim_q[0].task_id;
              data_handle_i <= stim_q[0].handle;
              send_req = 1'b1;
              void'(stim_q.pop_front());
            end
          end
          OP_CONFIG: begin
            cfg_index_i <= stim_q[0].cfg_idx;
            cfg_data_i <= stim_q[0].cfg_val;
            send_cfg = 1'b1;
            void'(stim_q.pop_front());
          end
          OP_DRAIN: begin
            if (expected_q.size() == 0) begin
              if (settle_cnt == SettleCycles) begin
                settle_cnt = 0;
                void'(stim_q.pop_front());
              end else begin
                settle_cnt++;
              end
            end
          end
          OP_HOLD: begin
            hold_requests <= hold_requests + 1;
            void'(stim_q.pop_front());
          end
          OP_CALM_ON: begin
            calm <= 1'b1;
            void'(stim_q.pop_front());
          end
          default: begin
            calm <= 1'b0;
            void'(stim_q.pop_front());
          end
        endcase
      end
      in_valid_i <= send_req;
      cfg_valid_i <= send_cfg;
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (holds_done != hold_requests) begin
        hold_left = LongHold;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      failures++;
      if (mismatches <= MaxReports) begin
        $display("result %0d: %s expected %h got %h", n_results, fname, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    timer_result_t want;
    sched_op_t seen;
    req_accepted = rst_ni && in_valid_i && !in_stall_o;
    cfg_accepted = rst_ni && cfg_valid_i && cfg_ready_o;

    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        failures++;
        $display("result transfer with nothing expected, status %0d", status_o);
      end else begin
        want = expected_q.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("fired", 32'(want.fired), 32'(fired_o));
        check_field("fired_task_id", 32'(want.task_id), 32'(fired_task_id_o));
        check_field("fired_data_handle", 32'(want.handle), 32'(fired_data_handle_o));
        check_field("wait_time", want.wait_ms, wait_time_o);
        check_field("occupancy", 32'(want.occupancy), 32'(occupancy_o));
        n_fired += want.fired;
        n_full += (want.status == STS_FULL);
        n_too_large += (want.status == STS_TOO_LARGE);
        n_not_found += (want.status == STS_NOT_FOUND);
      end
      n_results++;
    end

    if (cfg_accepted) begin
      case (cfg_index_i)
        CFG_IDLE_WAIT:   idle_wait_cfg = cfg_data_i;
        CFG_MAX_TIMEOUT: max_timeout_cfg = cfg_data_i[30:0];
        default: ;
      endcase
    end

    if (req_accepted) begin
      seen = '0;
      seen.req = req_type_i;
      seen.now = now_i;
      seen.timeout = timeout_i;
      seen.task_id = task_id_i;
      seen.handle = data_handle_i;
      case (req_type_i)
        REQ_REGISTER: n_register++;
        REQ_REMOVE:   n_remove++;
        REQ_POLL:     n_poll++;
        default:      n_unused++;
      endcase
      expected_q.push_back(timer_queue_step(seen));
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int unsigned end_wait;
    for (int unsigned k = 0; k < KeyPool; k++) begin
      pool_task[k] = TaskW'($urandom_range(0, 255));
      pool_handle[k] = HandleW'(k * 3299 + $urandom_range(0, 3));
    end

    // directed: empty poll, unused code, missing key, timeout limit, re-key, fire
    push_request(REQ_POLL, 32'h0, 32'h0, 8'h00, 16'h0000);
    push_request(ReqUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    push_request(REQ_REMOVE, 32'h0, 32'h0, 8'h5A, 16'h1234);
    push_request(REQ_REGISTER, 32'h0, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    push_request(REQ_REGISTER, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'hFF, 16'hFFFF);
    push_request(REQ_REGISTER, 32'h0, 32'h0, 8'h00, 16'h0000);
    push_request(REQ_REGISTER, 32'h0, 32'd5, 8'h00, 16'h0000);
    push_request(REQ_POLL, 32'h0, 32'h0, 8'h00, 16'h0000);
    push_request(REQ_POLL, 32'd5, 32'h0, 8'h00, 16'h0000);
    push_request(REQ_REMOVE, 32'h0, 32'h0, 8'hFF, 16'hFFFF);
    // fill to depth with tied expiries, overflow, then re-key while full
    for (int unsigned i = 0; i < QDepth; i++) begin
      push_request(REQ_REGISTER, 32'd100, i % 4, TaskW'(i), HandleW'(16'h8000 | i));
    end
    push_request(REQ_REGISTER, 32'd100, 32'd1, 8'h77, 16'h0077);
    push_request(REQ_REGISTER, 32'd100, 32'd2, 8'h03, 16'h8003);

    gen_clock = 32'd100;
    push_random(80);
    push_marker(OP_HOLD);
    push_random(170);
    push_marker(OP_DRAIN);

    push_config(CFG_IDLE_WAIT, 32'h0);
    push_config(CFG_MAX_TIMEOUT, 32'hFFFF_FFFF);
    push_config(CfgSpareIndex, $urandom);
    push_marker(OP_CALM_ON);
    push_random(200);
    push_marker(OP_CALM_OFF);
    push_marker(OP_DRAIN);

    push_config(CFG_IDLE_WAIT, 32'hFFFF_FFFF);
    push_config(CFG_MAX_TIMEOUT, 32'h0);
    push_random(80);
    push_marker(OP_DRAIN);

    // time counter crosses the wrap point
    push_config(CFG_IDLE_WAIT, $urandom);
    push_config(CFG_MAX_TIMEOUT, 32'd600);
    gen_clock = 32'hFFFF_FE00;
    push_random(150);
    push_marker(OP_HOLD);
    push_random(150);
    push_marker(OP_DRAIN);

    push_config(CFG_MAX_TIMEOUT, {1'b0, 31'($urandom)});
    push_random(170);
    push_marker(OP_DRAIN);

    while (stim_q.size() != 0 || in_valid_i || cfg_valid_i) @(posedge clk_i);
    end_wait = 0;
    while (expected_q.size() != 0 && end_wait < 5000) begin
      @(posedge clk_i);
      end_wait++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      failures += expected_q.size();
      $display("%0d expected results never arrived", expected_q.size());
    end

    $display("covered %0d results: %0d register, %0d remove, %0d poll, %0d unused code",
             n_results, n_register, n_remove, n_poll, n_unused);
    $display("  %0d tasks fired, %0d full, %0d timeout over limit, %0d key missing; %0d bad",
             n_fired, n_full, n_too_large, n_not_found, failures);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
